// ----- hdl/brfb_pkg.sv -----
package brfb_pkg;

  // Field widths of one item and one result
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned BYTE_W = 8;

  // Interleaved byte banks: one byte of a burst per bank
  localparam int unsigned BANKS  = 8;
  localparam int unsigned BANK_W = 3;

  // Byte count of one burst access (at most BANKS)
  localparam int unsigned NUM_W  = 4;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_ENABLE_ADDR = 3'd0;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SKIP  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_rdata;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
  } dp_sts_t;

endpackage

// ----- hdl/brfb_in_if.sv -----
interface brfb_in_if import brfb_pkg::*;;
  logic              valid;
  logic              ready;
  action_e           action;
  logic [LEN_W-1:0]  length;
  logic [DATA_W-1:0] put_data;

  modport source (output valid, action, length, put_data, input ready);
  modport sink   (input valid, action, length, put_data, output ready);
endinterface

// ----- hdl/brfb_out_if.sv -----
interface brfb_out_if import brfb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  count;
  logic [DATA_W-1:0] read_data;
  logic [LEN_W-1:0]  fill_level;

  modport source (output valid, count, read_data, fill_level, input ready);
  modport sink   (input valid, count, read_data, fill_level, output ready);
endinterface

// ----- hdl/brfb_ram.sv -----
module brfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/brfb_ctrl.sv -----
module brfb_ctrl import brfb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // Result slot is free when empty or being taken this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) state_d = sts_i.is_read ? ST_RDATA : ST_IDLE;
      end
      ST_RDATA: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o.load_item  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec       = (state_q == ST_EXEC) && slot_free;
    cmd_o.load_rdata = (state_q == ST_RDATA);
    out_valid_o      = out_valid_q;
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if ((cmd_o.exec && !sts_i.is_read) || cmd_o.load_rdata) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hdl/brfb_dp.sv -----
module brfb_dp import brfb_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned BURST = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_cmd_t          cmd_i,
  output dp_sts_t           sts_o,
  input  logic              enable_i,
  input  action_e           action_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [DATA_W-1:0] put_data_i,
  output logic [LEN_W-1:0]  count_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic [LEN_W-1:0]  fill_level_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned PW   = AW + 1;
  localparam int unsigned CW   = (PW > LEN_W ? PW : LEN_W) + 1;
  localparam int unsigned ROWS = DEPTH / BANKS;
  localparam int unsigned RW   = ROWS > 1 ? $clog2(ROWS) : 1;

  // Pointers (free running modulo 2*DEPTH)
  logic [PW-1:0]     wp_q, wp_d, rp_q, rp_d;
  // Item held for execution
  action_e           act_q;
  logic [LEN_W-1:0]  len_q;
  logic [DATA_W-1:0] pdata_q;
  // Result registers
  logic [LEN_W-1:0]  cnt_q;
  logic [LEN_W-1:0]  fill_q;
  logic [DATA_W-1:0] rdata_q;
  // Read burst alignment held for the data cycle
  logic [BANK_W-1:0] rd_lo_q;
  logic [NUM_W-1:0]  rd_n_q;

  logic [PW-1:0]     fill;
  logic [CW-1:0]     len_c, fill_c, space_c, burst_c, min_c, fill_after_c;
  logic              put_ok, skip_ok;
  logic [NUM_W-1:0]  rd_n;
  logic [LEN_W-1:0]  cnt_d;

  logic [RW-1:0]     wrow, wrow_inc, rrow, rrow_inc;
  logic              bank_we    [BANKS];
  logic [RW-1:0]     bank_waddr [BANKS];
  logic [BYTE_W-1:0] bank_wdata [BANKS];
  logic [RW-1:0]     bank_raddr [BANKS];
  logic [BYTE_W-1:0] bank_rdata [BANKS];
  logic [DATA_W-1:0] rdata_asm;

  assign sts_o.is_read = (act_q == ACT_READ);

  // Occupancy and admission checks
  always_comb begin
    fill    = wp_q - rp_q;
    len_c   = CW'(len_q);
    fill_c  = CW'(fill);
    space_c = CW'(DEPTH) - fill_c;
    burst_c = CW'(BURST);
    put_ok  = enable_i && (len_c <= burst_c) && (len_c <= space_c);
    skip_ok = (len_c <= fill_c);
    min_c   = (len_c < fill_c) ? len_c : fill_c;
    if (min_c > burst_c) min_c = burst_c;
    rd_n    = min_c[NUM_W-1:0];
  end

  // Pointer updates and byte count
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = '0;
    unique case (act_q)
      ACT_PUT: begin
        if (put_ok) begin
          wp_d  = wp_q + PW'(len_q);
          cnt_d = len_q;
        end
      end
      ACT_READ: begin
        rp_d  = rp_q + PW'(rd_n);
        cnt_d = LEN_W'(rd_n);
      end
      ACT_SKIP: begin
        if (skip_ok) begin
          rp_d  = rp_q + PW'(len_q);
          cnt_d = len_q;
        end
      end
      ACT_CLEAR: begin
        wp_d = '0;
        rp_d = '0;
      end
      default: ;
    endcase
    fill_after_c = CW'(PW'(wp_d - rp_d));
  end

  // Row addresses: banks below the start offset take the next row
  always_comb begin
    wrow     = RW'(wp_q[AW-1:0] >> BANK_W);
    wrow_inc = RW'((32'(wrow) + 32'd1) % ROWS);
    rrow     = RW'(rp_q[AW-1:0] >> BANK_W);
    rrow_inc = RW'((32'(rrow) + 32'd1) % ROWS);
  end

  // Steer burst bytes onto the banks
  always_comb begin
    logic [BANK_W-1:0] woff;
    for (int b = 0; b < BANKS; b++) begin
      woff          = BANK_W'(b) - wp_q[BANK_W-1:0];
      bank_we[b]    = cmd_i.exec && (act_q == ACT_PUT) && put_ok
                      && (LEN_W'(woff) < len_q);
      bank_waddr[b] = (BANK_W'(b) >= wp_q[BANK_W-1:0]) ? wrow : wrow_inc;
      bank_wdata[b] = pdata_q[BYTE_W*woff +: BYTE_W];
      bank_raddr[b] = (BANK_W'(b) >= rp_q[BANK_W-1:0]) ? rrow : rrow_inc;
    end
  end

  // Byte banks
  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    brfb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (bank_waddr[g]),
      .wdata_i (bank_wdata[g]),
      .raddr_i (bank_raddr[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  // Rotate bank outputs back into byte order and zero the unused bytes
  always_comb begin
    logic [BANK_W-1:0] bsel;
    for (int i = 0; i < BANKS; i++) begin
      bsel = rd_lo_q + BANK_W'(i);
      rdata_asm[BYTE_W*i +: BYTE_W] =
        (NUM_W'(i) < rd_n_q) ? bank_rdata[bsel] : '0;
    end
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else if (cmd_i.exec) begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  // Item capture and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q   <= action_i;
      len_q   <= length_i;
      pdata_q <= put_data_i;
    end
    if (cmd_i.exec) begin
      cnt_q   <= cnt_d;
      fill_q  <= fill_after_c[LEN_W-1:0];
      rdata_q <= '0;
      rd_lo_q <= rp_q[BANK_W-1:0];
      rd_n_q  <= rd_n;
    end
    if (cmd_i.load_rdata) begin
      rdata_q <= rdata_asm;
    end
  end

  assign count_o      = cnt_q;
  assign fill_level_o = fill_q;
  assign read_data_o  = rdata_q;

endmodule

// ----- hdl/byte_ring_fifo_burst.sv -----
// Byte ring buffer with burst put, read, skip and clear.
// A put, skip or clear result is registered as the execute state ends, once the
// result slot is free; a read result passes ST_RDATA too, for the registered bank read.
// One item is in work at a time; a new item is taken only in the idle state.
// Reset: pointers, enable and handshake state clear at once; the byte store is not cleared.
module byte_ring_fifo_burst import brfb_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned BURST = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  brfb_in_if.sink           in_i,
  brfb_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     enable_q;
  logic     enable_sel;

  // Decode the register word; the byte offset within a word is ignored
  assign enable_sel = (paddr[APB_AW-1:2] == REG_ENABLE_ADDR[APB_AW-1:2]);

  // Enable register on the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && enable_sel) begin
      enable_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = enable_sel ? APB_DW'(enable_q) : '0;

  brfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brfb_dp #(
    .DEPTH (DEPTH),
    .BURST (BURST)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .enable_i     (enable_q),
    .action_i     (in_i.action),
    .length_i     (in_i.length),
    .put_data_i   (in_i.put_data),
    .count_o      (out_o.count),
    .read_data_o  (out_o.read_data),
    .fill_level_o (out_o.fill_level)
  );

endmodule
